// ===== hw/rtl/ufrc_pkg.sv =====
// shared types, codes and sizing helpers for the uart fifo rs485 controller
`default_nettype none
package ufrc_pkg;

  localparam int unsigned TX_DEPTH_DEF = 256;
  localparam int unsigned RX_DEPTH_DEF = 256;
  localparam int unsigned FUNC_W       = 3;
  localparam int unsigned BYTE_W       = 8;
  // result flags and bytes ahead of the two level fields
  localparam int unsigned RES_FIXED_W  = 5 + 2 * BYTE_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT    = 3'd0,
    FUNC_GET    = 3'd1,
    FUNC_LINE_RX = 3'd2,
    FUNC_TX_RDY = 3'd3,
    FUNC_TX_CMP = 3'd4,
    FUNC_CLR_TX = 3'd5,
    FUNC_CLR_RX = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic in_load;
    logic exec;
    logic out_load;
  } ufrc_cmd_t;

  typedef struct packed {
    logic out_free;
  } ufrc_sts_t;

  function automatic int unsigned level_w(input int unsigned depth);
    return $clog2(depth + 1);
  endfunction

  function automatic int unsigned res_tdata_w(input int unsigned tx_d, input int unsigned rx_d);
    int unsigned w;
    w = RES_FIXED_W + level_w(tx_d) + level_w(rx_d);
    return ((w + 7) / 8) * 8;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ufrc_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none
module ufrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ufrc_ctrl.sv =====
// controller state machine: accept, execute, deliver
`default_nettype none
module ufrc_ctrl
  import ufrc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  input  wire ufrc_sts_t sts_i,
  output ufrc_cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_FIN;
      end
      ST_FIN: begin
        // ram read data is ready here; wait for the output register
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ufrc_dp.sv =====
// datapath: fifo pointers, fill counts, line control flags, rams and result register
`default_nettype none
module ufrc_dp
  import ufrc_pkg::*;
#(
  parameter int unsigned TX_DEPTH = TX_DEPTH_DEF,
  parameter int unsigned RX_DEPTH = RX_DEPTH_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire ufrc_cmd_t                              cmd_i,
  output ufrc_sts_t                                   sts_o,
  input  wire logic [BYTE_W-1:0]                      s_axis_tdata_i,
  input  wire logic [FUNC_W-1:0]                      s_axis_tuser_i,
  output logic                                        m_axis_tvalid_o,
  input  wire logic                                   m_axis_tready_i,
  output logic [res_tdata_w(TX_DEPTH, RX_DEPTH)-1:0]  m_axis_tdata_o
);

  localparam int unsigned TX_AW   = $clog2(TX_DEPTH);
  localparam int unsigned RX_AW   = $clog2(RX_DEPTH);
  localparam int unsigned TX_FW   = level_w(TX_DEPTH);
  localparam int unsigned RX_FW   = level_w(RX_DEPTH);
  localparam int unsigned RES_W   = RES_FIXED_W + TX_FW + RX_FW;
  localparam int unsigned TDATA_W = res_tdata_w(TX_DEPTH, RX_DEPTH);

  // captured transaction
  logic [FUNC_W-1:0] func_q;
  logic [BYTE_W-1:0] data_q;

  logic [TX_AW-1:0] tx_wptr_q, tx_wptr_d, tx_rptr_q, tx_rptr_d;
  logic [TX_FW-1:0] tx_fill_q, tx_fill_d;
  logic [RX_AW-1:0] rx_wptr_q, rx_wptr_d, rx_rptr_q, rx_rptr_d;
  logic [RX_FW-1:0] rx_fill_q, rx_fill_d;
  logic ready_armed_q, ready_armed_d;
  logic done_armed_q, done_armed_d;
  logic sending_q, sending_d;
  logic dir_tx_q, dir_tx_d;

  logic put_ok_q, put_ok_d;
  logic get_ok_q, get_ok_d;
  logic send_ok_q, send_ok_d;

  logic tx_wr_en, tx_rd_en, rx_wr_en, rx_rd_en;
  logic [BYTE_W-1:0] tx_rd_data, rx_rd_data;

  logic               out_valid_q;
  logic [TDATA_W-1:0] out_data_q;
  logic [RES_W-1:0]   res_pack;

  function automatic logic [TX_AW-1:0] tx_next(input logic [TX_AW-1:0] p);
    return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [RX_AW-1:0] rx_next(input logic [RX_AW-1:0] p);
    return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      func_q <= s_axis_tuser_i;
      data_q <= s_axis_tdata_i;
    end
  end

  always_comb begin
    tx_wptr_d     = tx_wptr_q;
    tx_rptr_d     = tx_rptr_q;
    tx_fill_d     = tx_fill_q;
    rx_wptr_d     = rx_wptr_q;
    rx_rptr_d     = rx_rptr_q;
    rx_fill_d     = rx_fill_q;
    ready_armed_d = ready_armed_q;
    done_armed_d  = done_armed_q;
    sending_d     = sending_q;
    dir_tx_d      = dir_tx_q;
    put_ok_d      = put_ok_q;
    get_ok_d      = get_ok_q;
    send_ok_d     = send_ok_q;
    tx_wr_en      = 1'b0;
    tx_rd_en      = 1'b0;
    rx_wr_en      = 1'b0;
    rx_rd_en      = 1'b0;
    if (cmd_i.exec) begin
      put_ok_d  = 1'b0;
      get_ok_d  = 1'b0;
      send_ok_d = 1'b0;
      unique case (func_e'(func_q))
        FUNC_PUT: begin
          dir_tx_d      = 1'b1;
          ready_armed_d = 1'b1;
          if (tx_fill_q != TX_FW'(TX_DEPTH)) begin
            tx_wr_en  = 1'b1;
            tx_wptr_d = tx_next(tx_wptr_q);
            tx_fill_d = tx_fill_q + 1'b1;
            put_ok_d  = 1'b1;
          end
        end
        FUNC_GET: begin
          if (rx_fill_q != '0) begin
            rx_rd_en  = 1'b1;
            rx_rptr_d = rx_next(rx_rptr_q);
            rx_fill_d = rx_fill_q - 1'b1;
            get_ok_d  = 1'b1;
          end
        end
        FUNC_LINE_RX: begin
          // a full fifo overwrites the oldest slot, the count saturates
          rx_wr_en  = 1'b1;
          rx_wptr_d = rx_next(rx_wptr_q);
          if (rx_fill_q != RX_FW'(RX_DEPTH)) begin
            rx_fill_d = rx_fill_q + 1'b1;
          end
        end
        FUNC_TX_RDY: begin
          if (ready_armed_q) begin
            if (tx_fill_q == '0) begin
              ready_armed_d = 1'b0;
              done_armed_d  = 1'b1;
            end else begin
              sending_d = 1'b1;
              tx_rd_en  = 1'b1;
              tx_rptr_d = tx_next(tx_rptr_q);
              tx_fill_d = tx_fill_q - 1'b1;
              send_ok_d = 1'b1;
            end
          end
        end
        FUNC_TX_CMP: begin
          if (done_armed_q) begin
            if (tx_fill_q == '0) begin
              done_armed_d = 1'b0;
              dir_tx_d     = 1'b0;
              sending_d    = 1'b0;
            end else begin
              tx_rd_en  = 1'b1;
              tx_rptr_d = tx_next(tx_rptr_q);
              tx_fill_d = tx_fill_q - 1'b1;
              send_ok_d = 1'b1;
            end
          end
        end
        FUNC_CLR_TX: begin
          tx_wptr_d = '0;
          tx_rptr_d = '0;
          tx_fill_d = '0;
        end
        FUNC_CLR_RX: begin
          rx_wptr_d = '0;
          rx_rptr_d = '0;
          rx_fill_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_wptr_q     <= '0;
      tx_rptr_q     <= '0;
      tx_fill_q     <= '0;
      rx_wptr_q     <= '0;
      rx_rptr_q     <= '0;
      rx_fill_q     <= '0;
      ready_armed_q <= 1'b0;
      done_armed_q  <= 1'b0;
      sending_q     <= 1'b0;
      dir_tx_q      <= 1'b0;
      put_ok_q      <= 1'b0;
      get_ok_q      <= 1'b0;
      send_ok_q     <= 1'b0;
    end else begin
      tx_wptr_q     <= tx_wptr_d;
      tx_rptr_q     <= tx_rptr_d;
      tx_fill_q     <= tx_fill_d;
      rx_wptr_q     <= rx_wptr_d;
      rx_rptr_q     <= rx_rptr_d;
      rx_fill_q     <= rx_fill_d;
      ready_armed_q <= ready_armed_d;
      done_armed_q  <= done_armed_d;
      sending_q     <= sending_d;
      dir_tx_q      <= dir_tx_d;
      put_ok_q      <= put_ok_d;
      get_ok_q      <= get_ok_d;
      send_ok_q     <= send_ok_d;
    end
  end

  ufrc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk_i     (clk_i),
    .wr_en_i   (tx_wr_en),
    .wr_addr_i (tx_wptr_q),
    .wr_data_i (data_q),
    .rd_en_i   (tx_rd_en),
    .rd_addr_i (tx_rptr_q),
    .rd_data_o (tx_rd_data)
  );

  ufrc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk_i     (clk_i),
    .wr_en_i   (rx_wr_en),
    .wr_addr_i (rx_wptr_q),
    .wr_data_i (data_q),
    .rd_en_i   (rx_rd_en),
    .rd_addr_i (rx_rptr_q),
    .rd_data_o (rx_rd_data)
  );

  // levels and flags already hold the post-event values in the finish cycle
  assign res_pack = {rx_fill_q, tx_fill_q, sending_q, dir_tx_q,
                     (send_ok_q ? tx_rd_data : BYTE_W'(0)), send_ok_q,
                     (get_ok_q ? rx_rd_data : BYTE_W'(0)), get_ok_q, put_ok_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= TDATA_W'(res_pack);
    end
  end

  assign sts_o.out_free  = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
`default_nettype wire

// ===== hw/rtl/uart_fifo_rs485_controller_core.sv =====
// sequence: accept, execute with ram access, registered ram read and result load; a new
// event is accepted only after the previous result has been loaded into the output register;
// input is taken again while a result waits at the output
// reset: asynchronous active-low rst_ni clears pointers, fill counts, line flags and
// the output valid; fifo rams are not cleared and are never read before being written
`default_nettype none
module uart_fifo_rs485_controller_core
  import ufrc_pkg::*;
#(
  parameter int unsigned TX_DEPTH = TX_DEPTH_DEF,
  parameter int unsigned RX_DEPTH = RX_DEPTH_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  // data
  input  wire logic [BYTE_W-1:0]                      s_axis_tdata_i,
  // func
  input  wire logic [FUNC_W-1:0]                      s_axis_tuser_i,
  output logic                                        m_axis_tvalid_o,
  input  wire logic                                   m_axis_tready_i,
  // put_accepted, get_valid, get_byte, send_valid, send_byte, driver_enable,
  // busy_res, tx_level, rx_level, zero fill
  output logic [res_tdata_w(TX_DEPTH, RX_DEPTH)-1:0]  m_axis_tdata_o
);

  ufrc_cmd_t cmd;
  ufrc_sts_t sts;

  ufrc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  ufrc_dp #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule
`default_nettype wire

// ===== test/tb_uart_fifo_rs485_controller_core.sv =====
// testbench for the uart fifo rs485 controller core: event stream checked against a scoreboard
module tb_uart_fifo_rs485_controller_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ufrc_pkg::*;

  localparam int unsigned TX_DEPTH      = TX_DEPTH_DEF;
  localparam int unsigned RX_DEPTH      = RX_DEPTH_DEF;
  localparam int unsigned TX_LVL_W      = level_w(TX_DEPTH);
  localparam int unsigned RX_LVL_W      = level_w(RX_DEPTH);
  localparam int unsigned RES_W         = res_tdata_w(TX_DEPTH, RX_DEPTH);
  localparam int unsigned RANDOM_EVENTS = 800;
  localparam int unsigned DIR_N         = 25;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam int unsigned MAX_CYCLES    = 400000;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;

  typedef struct packed {
    logic [RX_LVL_W-1:0] rx_level;
    logic [TX_LVL_W-1:0] tx_level;
    logic                busy;
    logic                drv_en;
    logic [BYTE_W-1:0]   send_byte;
    logic                send_valid;
    logic [BYTE_W-1:0]   get_byte;
    logic                get_valid;
    logic                put_ok;
  } event_res_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] data;
    logic              typed;
    event_res_t        res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [BYTE_W-1:0] s_axis_tdata_i = '0;
  logic [FUNC_W-1:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [RES_W-1:0] m_axis_tdata_o;

  always #6 clk_i = ~clk_i;

  uart_fifo_rs485_controller_core #(
    .TX_DEPTH(TX_DEPTH),
    .RX_DEPTH(RX_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // shadow of the controller state
  logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
  logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
  int unsigned tx_wr = 0, tx_rd = 0, tx_cnt = 0;
  int unsigned rx_wr = 0, rx_rd = 0, rx_cnt = 0;
  bit rdy_armed = 1'b0, cmp_armed = 1'b0, busy_q = 1'b0, drv_q = 1'b0;

  event_res_t pending_results [$];
  int unsigned errors = 0, cycle_count = 0, results_seen = 0;
  int unsigned events_total = 0, active_events = 0;
  int unsigned sent_bytes = 0, got_bytes = 0, refused_puts = 0, rx_overwrites = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  function automatic int unsigned draw_wait();
    if (no_idle || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [BYTE_W-1:0] next_tx_byte();
    logic [BYTE_W-1:0] b;
    b = tx_mem[tx_rd];
    tx_rd = (tx_rd + 1) % TX_DEPTH;
    tx_cnt--;
    sent_bytes++;
    return b;
  endfunction

  task automatic apply_event(input logic [FUNC_W-1:0] func, input logic [BYTE_W-1:0] data,
                             output event_res_t res, output bit acted);
    res = '0;
    acted = 1'b1;
    case (func)
      FUNC_PUT: begin
        drv_q = 1'b1;
        rdy_armed = 1'b1;
        if (tx_cnt < TX_DEPTH) begin
          tx_mem[tx_wr] = data;
          tx_wr = (tx_wr + 1) % TX_DEPTH;
          tx_cnt++;
          res.put_ok = 1'b1;
        end else begin
          refused_puts++;
        end
      end
      FUNC_GET: begin
        if (rx_cnt != 0) begin
          res.get_valid = 1'b1;
          res.get_byte = rx_mem[rx_rd];
          rx_rd = (rx_rd + 1) % RX_DEPTH;
          rx_cnt--;
          got_bytes++;
        end else begin
          acted = 1'b0;
        end
      end
      FUNC_LINE_RX: begin
        // a full fifo keeps its count and read pointer, the oldest slot is overwritten
        rx_mem[rx_wr] = data;
        rx_wr = (rx_wr + 1) % RX_DEPTH;
        if (rx_cnt < RX_DEPTH) rx_cnt++;
        else rx_overwrites++;
      end
      FUNC_TX_RDY: begin
        if (!rdy_armed) begin
          acted = 1'b0;
        end else if (tx_cnt == 0) begin
          rdy_armed = 1'b0;
          cmp_armed = 1'b1;
        end else begin
          busy_q = 1'b1;
          res.send_valid = 1'b1;
          res.send_byte = next_tx_byte();
        end
      end
      FUNC_TX_CMP: begin
        if (!cmp_armed) begin
          acted = 1'b0;
        end else if (tx_cnt == 0) begin
          cmp_armed = 1'b0;
          drv_q = 1'b0;
          busy_q = 1'b0;
        end else begin
          res.send_valid = 1'b1;
          res.send_byte = next_tx_byte();
        end
      end
      FUNC_CLR_TX: begin
        tx_wr = 0;
        tx_rd = 0;
        tx_cnt = 0;
      end
      FUNC_CLR_RX: begin
        rx_wr = 0;
        rx_rd = 0;
        rx_cnt = 0;
      end
      default: acted = 1'b0;
    endcase
    res.drv_en = drv_q;
    res.busy = busy_q;
    res.tx_level = TX_LVL_W'(tx_cnt);
    res.rx_level = RX_LVL_W'(rx_cnt);
  endtask

  // offers one event after a random gap and records its expected result once taken
  task automatic send_event(input logic [FUNC_W-1:0] func, input logic [BYTE_W-1:0] data,
                            input bit has_fixed = 1'b0, input event_res_t fixed_res = '0);
    int unsigned gap;
    event_res_t res;
    bit acted;
    gap = draw_wait();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= func;
    s_axis_tdata_i  <= data;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    apply_event(func, data, res, acted);
    pending_results.push_back(has_fixed ? fixed_res : res);
    events_total++;
    if (acted) active_events++;
  endtask

  function automatic void cmp_field(input string name, input logic [15:0] want,
                                    input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    event_res_t got;
    event_res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[$bits(event_res_t)-1:0];
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual %h",
                 $time, m_axis_tdata_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        cmp_field("put_accepted", 16'(want.put_ok), 16'(got.put_ok));
        cmp_field("get_valid", 16'(want.get_valid), 16'(got.get_valid));
        cmp_field("get_byte", 16'(want.get_byte), 16'(got.get_byte));
        cmp_field("send_valid", 16'(want.send_valid), 16'(got.send_valid));
        cmp_field("send_byte", 16'(want.send_byte), 16'(got.send_byte));
        cmp_field("driver_enable", 16'(want.drv_en), 16'(got.drv_en));
        cmp_field("busy_res", 16'(want.busy), 16'(got.busy));
        cmp_field("tx_level", 16'(want.tx_level), 16'(got.tx_level));
        cmp_field("rx_level", 16'(want.rx_level), 16'(got.rx_level));
      end
      if ((m_axis_tdata_o >> $bits(event_res_t)) != '0) begin
        $display("%0t: fill bits, expected 0, actual %h", $time, m_axis_tdata_o);
        errors++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random stall per transaction, one long hold-off on request
  initial begin
    int unsigned stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = draw_wait();
      end
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
    end
  end

  initial begin
    dir_row_t dir_rows [DIR_N];
    event_res_t put_first;
    int unsigned n;
    bit tx_burst_done;
    bit rx_burst_done;
    tx_burst_done = 1'b0;
    rx_burst_done = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    put_first = '0;
    put_first.put_ok = 1'b1;
    put_first.drv_en = 1'b1;
    put_first.tx_level = 1;

    // events on the reset state leave everything at zero
    dir_rows[0]  = '{FUNC_GET,     8'h00, 1'b1, '0};
    dir_rows[1]  = '{FUNC_TX_RDY,  8'hFF, 1'b1, '0};
    dir_rows[2]  = '{FUNC_TX_CMP,  8'h55, 1'b1, '0};
    dir_rows[3]  = '{FUNC_UNUSED,  8'hAA, 1'b1, '0};
    dir_rows[4]  = '{FUNC_CLR_TX,  8'hFF, 1'b1, '0};
    dir_rows[5]  = '{FUNC_CLR_RX,  8'h00, 1'b1, '0};
    dir_rows[6]  = '{FUNC_PUT,     8'h00, 1'b1, put_first};
    dir_rows[7]  = '{FUNC_PUT,     8'hFF, 1'b0, '0};
    dir_rows[8]  = '{FUNC_TX_RDY,  8'h00, 1'b0, '0};
    dir_rows[9]  = '{FUNC_TX_RDY,  8'h00, 1'b0, '0};
    dir_rows[10] = '{FUNC_TX_RDY,  8'h00, 1'b0, '0};
    // completion arrives while a fresh byte waits
    dir_rows[11] = '{FUNC_PUT,     8'hA5, 1'b0, '0};
    dir_rows[12] = '{FUNC_TX_CMP,  8'h00, 1'b0, '0};
    dir_rows[13] = '{FUNC_TX_RDY,  8'h00, 1'b0, '0};
    dir_rows[14] = '{FUNC_TX_CMP,  8'h00, 1'b0, '0};
    dir_rows[15] = '{FUNC_LINE_RX, 8'h00, 1'b0, '0};
    dir_rows[16] = '{FUNC_LINE_RX, 8'hFF, 1'b0, '0};
    dir_rows[17] = '{FUNC_GET,     8'h00, 1'b0, '0};
    dir_rows[18] = '{FUNC_GET,     8'h00, 1'b0, '0};
    dir_rows[19] = '{FUNC_GET,     8'hFF, 1'b0, '0};
    dir_rows[20] = '{FUNC_LINE_RX, 8'h3C, 1'b0, '0};
    dir_rows[21] = '{FUNC_CLR_RX,  8'h00, 1'b0, '0};
    dir_rows[22] = '{FUNC_PUT,     8'h81, 1'b0, '0};
    dir_rows[23] = '{FUNC_CLR_TX,  8'h00, 1'b0, '0};
    dir_rows[24] = '{FUNC_TX_RDY,  8'h00, 1'b0, '0};

    foreach (dir_rows[i])
      send_event(dir_rows[i].func, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].res);
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);

    while (events_total < RANDOM_EVENTS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if (!tx_burst_done && events_total >= 150) begin
        tx_burst_done = 1'b1;
        // overfill, drain a little and refill so the write pointer wraps
        repeat (TX_DEPTH + $urandom_range(1, 4)) send_event(FUNC_PUT, 8'($urandom));
        repeat ($urandom_range(1, 8)) send_event(FUNC_TX_RDY, 8'($urandom));
        repeat ($urandom_range(1, 8)) send_event(FUNC_PUT, 8'($urandom));
        send_event(FUNC_CLR_TX, 8'($urandom));
        s_axis_tvalid_i <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end else if (!rx_burst_done && events_total >= 450) begin
        rx_burst_done = 1'b1;
        // result side stalls long while line bytes keep coming
        hold_req = 1'b1;
        no_idle = 1'b1;
        repeat (RX_DEPTH + $urandom_range(1, 6)) send_event(FUNC_LINE_RX, 8'($urandom));
        repeat ($urandom_range(1, 10)) send_event(FUNC_GET, 8'($urandom));
        send_event(FUNC_CLR_RX, 8'($urandom));
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            // host message: puts, ready events until drained, then completion
            n = $urandom_range(1, 16);
            repeat (n) send_event(FUNC_PUT, 8'($urandom));
            repeat (n + $urandom_range(0, 3))
              send_event(($urandom_range(0, 5) == 0) ? FUNC_TX_CMP : FUNC_TX_RDY,
                         8'($urandom));
            send_event(FUNC_TX_CMP, 8'($urandom));
          end
          4, 5, 6: begin
            n = $urandom_range(1, 16);
            repeat (n) send_event(FUNC_LINE_RX, 8'($urandom));
            repeat (n + $urandom_range(0, 2)) send_event(FUNC_GET, 8'($urandom));
          end
          default: begin
            repeat ($urandom_range(4, 16))
              send_event(3'($urandom_range(0, 6)), 8'($urandom));
          end
        endcase
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d events offered (%0d changed state), %0d results checked",
             events_total, active_events, results_seen);
    $display("%0d bytes to transmitter, %0d bytes read back, %0d puts refused, %0d rx overwrites",
             sent_bytes, got_bytes, refused_puts, rx_overwrites);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
